[hw/rtl/weighted_block_downsampler_assert.svh]
// assertion macros for the weighted block downsampler checker
// no dependencies; included by the checker file
`ifndef WEIGHTED_BLOCK_DOWNSAMPLER_ASSERT_SVH
`define WEIGHTED_BLOCK_DOWNSAMPLER_ASSERT_SVH

// clocked assertion, off while reset is active
`define WBD_ASSERT_RST(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked assertion that also runs during reset
`define WBD_ASSERT_CLK(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[hw/rtl/wbd_pkg.sv]
// shared types and constants for the weighted block downsampler
// no dependencies; used by the output and register interfaces and the top level
package wbd_pkg;

  localparam int CELL_SIZE_W = 7;
  localparam int COLS_W      = 11;
  localparam int ROWS_W      = 11;
  localparam int LIMIT_W     = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_IDX_W   = 10;
  localparam int ROW_LIMIT   = 1024;

  localparam logic [CELL_SIZE_W-1:0]   CELL_SIZE_RST     = 7'd4;
  localparam logic [COLS_W-1:0]        COLS_RST          = 11'd64;
  localparam logic [ROWS_W-1:0]        ROWS_RST          = 11'd64;
  localparam logic signed [LIMIT_W-1:0] MISSING_LIMIT_RST = 32'sh7fff_ffff;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CELL_SIZE     = 8'd0,
    REG_COARSE_COLS   = 8'd1,
    REG_COARSE_ROWS   = 8'd2,
    REG_MISSING_LIMIT = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_INIT,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

[hw/rtl/wbd_in_if.sv]
// sample request channel of the weighted block downsampler
// depends on nothing
interface wbd_in_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[hw/rtl/wbd_out_if.sv]
// cell result channel of the weighted block downsampler
// depends on wbd_pkg
interface wbd_out_if import wbd_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          empty_cell;
  logic [OUT_IDX_W-1:0]          cell_row;
  logic [OUT_IDX_W-1:0]          cell_col;
  logic                          frame_last;

  modport source (output valid, output average, output empty_cell, output cell_row,
                  output cell_col, output frame_last, input ready);
  modport sink (input valid, input average, input empty_cell, input cell_row,
                input cell_col, input frame_last, output ready);
endinterface

[hw/rtl/wbd_cfg_if.sv]
// register write channel of the weighted block downsampler
// depends on wbd_pkg
interface wbd_cfg_if import wbd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/weighted_block_downsampler.sv]
// weighted block downsampler: trapezoidal cell averages over a raster grid
// depends on wbd_pkg, wbd_in_if, wbd_out_if, wbd_cfg_if
// throughput: one sample per cycle when no register write is waiting, except that a corner
//   sample holds off further requests while the one-bit-per-cycle divider runs and until
//   its result is loaded into the output register
// reset: synchronous, restores configuration defaults and clears position, carry, divider state and output valid
module weighted_block_downsampler import wbd_pkg::*; #(
  parameter int MAX_COARSE_COLS = 1024,
  parameter int MAX_CELL_SIZE   = 64,
  parameter int SAMPLE_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  wbd_in_if.sink    in_ch,
  wbd_out_if.source out_ch,
  wbd_cfg_if.sink   cfg_ch
);

  localparam int SB    = SAMPLE_BITS;
  localparam int WW    = $clog2(4 * MAX_CELL_SIZE * MAX_CELL_SIZE + 1);
  localparam int SUMW  = SB + WW;
  localparam int MEMW  = SUMW + WW;
  localparam int NW    = SUMW + 1;
  localparam int QW    = SB;
  localparam int RW    = WW + 2;
  localparam int CW    = $clog2(SB);
  localparam int XW    = (SB > LIMIT_W) ? SB : LIMIT_W;
  localparam int SUBW  = $clog2(MAX_CELL_SIZE);
  localparam int SZW   = $clog2(MAX_CELL_SIZE + 1);
  localparam int KW    = $clog2(MAX_COARSE_COLS);
  localparam int KCW   = $clog2(MAX_COARSE_COLS + 1);
  localparam int RCW   = $clog2(ROW_LIMIT + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(SB - 1);

  // configuration
  logic [CELL_SIZE_W-1:0]       cell_size_r;
  logic [COLS_W-1:0]            cols_r;
  logic [ROWS_W-1:0]            rows_r;
  logic signed [LIMIT_W-1:0]    limit_r;
  logic [SZW-1:0]               size_eff;
  logic [KCW-1:0]               cols_eff;
  logic [RCW-1:0]               rows_eff;

  // position and horizontal carry
  logic [SUBW-1:0]              sub_c_r, sub_r_r;
  logic [KCW-1:0]               kc_r;
  logic [RCW-1:0]               mr_r;
  logic signed [SUMW-1:0]       carry_sum_r;
  logic [WW-1:0]                carry_w_r;

  // request stage
  logic                         in_acc, cfg_acc;
  logic signed [SB-1:0]         x;
  logic                         smp_ok, h_edge, v_edge;
  logic signed [SUMW-1:0]       ws, ps;
  logic [1:0]                   wt;
  logic [WW-1:0]                pw;
  logic [KW-1:0]                rd_addr;

  // column store stage
  logic [MEMW-1:0]              col_mem [MAX_COARSE_COLS];
  logic [MEMW-1:0]              mem_rd_r;
  logic                         s1_valid_r, s1_mem_r, s1_vedge_r, s1_emit_r, s1_last_r;
  logic signed [SUMW-1:0]       s1_ps_r;
  logic [WW-1:0]                s1_pw_r;
  logic [KW-1:0]                s1_k_r;
  logic [OUT_IDX_W-1:0]         s1_m_r;
  logic signed [SUMW-1:0]       col_sum, acc_sum, ts;
  logic [WW-1:0]                col_w, acc_w, tw;
  logic                         mem_we, job_load;
  logic [MEMW-1:0]              mem_wdata;

  // divider
  div_state_t                   div_state_r, div_state_nxt;
  logic                         out_load;
  logic signed [SUMW-1:0]       job_ts_r;
  logic [WW-1:0]                job_tw_r;
  logic                         job_neg_r, job_last_r;
  logic [OUT_IDX_W-1:0]         job_row_r, job_col_r;
  logic [RW-1:0]                rem_r, shifted, div_d;
  logic [QW-1:0]                nq_r;
  logic [CW-1:0]                cnt_r;
  logic [NW-1:0]                num;
  logic                         ge;
  logic [QW-1:0]                avg;

  // output register
  logic                         out_valid_r;
  logic signed [SB-1:0]         out_avg_r;
  logic                         out_empty_r, out_last_r;
  logic [OUT_IDX_W-1:0]         out_row_r, out_col_r;

  // clamped configuration
  always_comb begin
    if (cell_size_r < CELL_SIZE_W'(2)) begin
      size_eff = SZW'(2);
    end else if (32'(cell_size_r) > 32'(MAX_CELL_SIZE)) begin
      size_eff = SZW'(MAX_CELL_SIZE);
    end else begin
      size_eff = SZW'(cell_size_r);
    end
    if (cols_r == '0) begin
      cols_eff = KCW'(1);
    end else if (32'(cols_r) > 32'(MAX_COARSE_COLS)) begin
      cols_eff = KCW'(MAX_COARSE_COLS);
    end else begin
      cols_eff = KCW'(cols_r);
    end
    if (rows_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(rows_r) > 32'(ROW_LIMIT)) begin
      rows_eff = RCW'(ROW_LIMIT);
    end else begin
      rows_eff = RCW'(rows_r);
    end
  end

  assign in_ch.ready  = (div_state_r == DIV_IDLE) && !job_load && !cfg_ch.valid;
  assign cfg_ch.ready = (div_state_r == DIV_IDLE) && !s1_valid_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  // weighting of the incoming sample
  always_comb begin
    x       = in_ch.sample;
    smp_ok  = XW'(x) < XW'(limit_r);
    h_edge  = (sub_c_r == '0);
    v_edge  = (sub_r_r == '0);
    if (!smp_ok) begin
      ws = '0;
      wt = 2'd0;
    end else if (h_edge) begin
      ws = SUMW'(x);
      wt = 2'd1;
    end else begin
      ws = SUMW'(x) <<< 1;
      wt = 2'd2;
    end
    ps      = carry_sum_r + ws;
    pw      = carry_w_r + WW'(wt);
    rd_addr = KW'(kc_r - KCW'(1));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
      cols_r      <= COLS_RST;
      rows_r      <= ROWS_RST;
      limit_r     <= MISSING_LIMIT_RST;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CELL_SIZE:     cell_size_r <= cfg_ch.data[CELL_SIZE_W-1:0];
        REG_COARSE_COLS:   cols_r      <= cfg_ch.data[COLS_W-1:0];
        REG_COARSE_ROWS:   rows_r      <= cfg_ch.data[ROWS_W-1:0];
        REG_MISSING_LIMIT: limit_r     <= signed'(cfg_ch.data[LIMIT_W-1:0]);
        default: ;
      endcase
    end
  end

  // position counters and horizontal carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_c_r     <= '0;
      kc_r        <= '0;
      sub_r_r     <= '0;
      mr_r        <= '0;
      carry_sum_r <= '0;
      carry_w_r   <= '0;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CELL_SIZE, REG_COARSE_COLS, REG_COARSE_ROWS, REG_MISSING_LIMIT: begin
          sub_c_r     <= '0;
          kc_r        <= '0;
          sub_r_r     <= '0;
          mr_r        <= '0;
          carry_sum_r <= '0;
          carry_w_r   <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      if (h_edge) begin
        carry_sum_r <= ws;
        carry_w_r   <= WW'(wt);
      end else begin
        carry_sum_r <= ps;
        carry_w_r   <= pw;
      end
      if (kc_r == cols_eff) begin
        sub_c_r <= '0;
        kc_r    <= '0;
        if (mr_r == rows_eff) begin
          sub_r_r <= '0;
          mr_r    <= '0;
        end else if (SZW'(sub_r_r) + SZW'(1) == size_eff) begin
          sub_r_r <= '0;
          mr_r    <= mr_r + RCW'(1);
        end else begin
          sub_r_r <= sub_r_r + SUBW'(1);
        end
      end else if (SZW'(sub_c_r) + SZW'(1) == size_eff) begin
        sub_c_r <= '0;
        kc_r    <= kc_r + KCW'(1);
      end else begin
        sub_c_r <= sub_c_r + SUBW'(1);
      end
    end
  end

  // request stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mem_r   <= h_edge && (kc_r != '0);
      s1_vedge_r <= v_edge;
      s1_emit_r  <= v_edge && (mr_r != '0);
      s1_last_r  <= (kc_r == cols_eff) && (mr_r == rows_eff);
      s1_ps_r    <= ps;
      s1_pw_r    <= pw;
      s1_k_r     <= rd_addr;
      s1_m_r     <= OUT_IDX_W'(mr_r - RCW'(1));
    end
  end

  // column store read-modify-write
  always_comb begin
    col_sum   = signed'(mem_rd_r[MEMW-1:WW]);
    col_w     = mem_rd_r[WW-1:0];
    acc_sum   = col_sum + (s1_ps_r <<< 1);
    acc_w     = col_w + (s1_pw_r << 1);
    ts        = col_sum + s1_ps_r;
    tw        = col_w + s1_pw_r;
    mem_we    = s1_valid_r && s1_mem_r;
    job_load  = mem_we && s1_vedge_r && s1_emit_r;
    mem_wdata = s1_vedge_r ? {s1_ps_r, s1_pw_r} : {acc_sum, acc_w};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[s1_k_r] <= mem_wdata;
    end
    if (in_acc) begin
      mem_rd_r <= col_mem[rd_addr];
    end
  end

  // divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
    end else begin
      div_state_r <= div_state_nxt;
    end
  end

  always_comb begin
    div_state_nxt = div_state_r;
    out_load      = 1'b0;
    case (div_state_r)
      DIV_IDLE: begin
        if (job_load) begin
          div_state_nxt = DIV_ABS;
        end
      end
      DIV_ABS:  div_state_nxt = DIV_INIT;
      DIV_INIT: div_state_nxt = DIV_RUN;
      DIV_RUN: begin
        if (cnt_r == CNT_LAST) begin
          div_state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          div_state_nxt = DIV_IDLE;
        end
      end
      default: div_state_nxt = DIV_IDLE;
    endcase
  end

  // rounded quotient (2|sum| + w) / 2w, one bit per cycle
  always_comb begin
    num     = NW'({job_ts_r, 1'b0}) + NW'(job_tw_r);
    div_d   = RW'({job_tw_r, 1'b0});
    shifted = {rem_r[RW-2:0], nq_r[QW-1]};
    ge      = shifted >= div_d;
    avg     = job_neg_r ? (~nq_r + QW'(1)) : nq_r;
  end

  always_ff @(posedge clk) begin
    case (div_state_r)
      DIV_IDLE: begin
        if (job_load) begin
          job_ts_r   <= ts;
          job_tw_r   <= tw;
          job_row_r  <= s1_m_r;
          job_col_r  <= OUT_IDX_W'(s1_k_r);
          job_last_r <= s1_last_r;
        end
      end
      DIV_ABS: begin
        job_neg_r <= job_ts_r[SUMW-1];
        job_ts_r  <= job_ts_r[SUMW-1] ? -job_ts_r : job_ts_r;
      end
      DIV_INIT: begin
        rem_r <= RW'(num[NW-1:QW]);
        nq_r  <= num[QW-1:0];
        cnt_r <= '0;
      end
      DIV_RUN: begin
        rem_r <= ge ? (shifted - div_d) : shifted;
        nq_r  <= {nq_r[QW-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r   <= (job_tw_r == '0) ? '0 : signed'(avg);
      out_empty_r <= (job_tw_r == '0);
      out_row_r   <= job_row_r;
      out_col_r   <= job_col_r;
      out_last_r  <= job_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.average    = out_avg_r;
  assign out_ch.empty_cell = out_empty_r;
  assign out_ch.cell_row   = out_row_r;
  assign out_ch.cell_col   = out_col_r;
  assign out_ch.frame_last = out_last_r;

endmodule

[hw/rtl/wbd_checker.sv]
// port-level checks for the weighted block downsampler, bound to the top level
// depends on weighted_block_downsampler_assert.svh and weighted_block_downsampler
`include "weighted_block_downsampler_assert.svh"
module wbd_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_average,
  input logic                   out_empty_cell,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  `WBD_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_average), "stalled result changed")
  `WBD_ASSERT_RST(a_empty_zero, clk, rst_n, out_valid && out_empty_cell |-> out_average == '0, "empty cell with nonzero average")
  `WBD_ASSERT_RST(a_no_overlap, clk, rst_n, !(in_valid && in_ready && cfg_valid && cfg_ready), "sample and register write in one cycle")
  `WBD_ASSERT_CLK(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind weighted_block_downsampler wbd_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_average    (out_ch.average),
  .out_empty_cell (out_ch.empty_cell),
  .cfg_valid      (cfg_ch.valid),
  .cfg_ready      (cfg_ch.ready)
);
